// ===== hw/rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants of the set-associative LRU cache model
// Access kinds, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 32;
    localparam int KIND_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_REREAD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic read_in;
        logic read_again;
        logic lookup;
        logic update;
        logic first;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_ctrl_stat;

endpackage

// ===== hw/rtl/slc_ctrl.sv =====
// ----------------------------------------------------------------------------
// slc_ctrl: access sequencer
// Steps each item through set read, way compare and row write-back (twice
// for a modify, not at all for an unused kind) and loads the output register.
// ----------------------------------------------------------------------------
module slc_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [slc_pkg::KIND_W-1:0]     i_kind,
    input  slc_pkg::t_ctrl_stat            i_stat,
    output slc_pkg::t_ctrl_cmd             o_cmd
);
    import slc_pkg::*;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_second <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_first  <= n_first;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_first  = r_first;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_second = (i_kind == KIND_MODIFY);
                    n_first  = 1'b1;
                    if (i_kind == KIND_NONE) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_first = 1'b0;
                if (r_second) begin
                    n_second = 1'b0;
                    n_state  = ST_REREAD;
                end else if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_REREAD: begin
                n_state = ST_LOOKUP;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept  = 1'b1;
                    o_cmd.read_in = (i_kind != KIND_NONE);
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.update   = 1'b1;
                o_cmd.first    = r_first;
                o_cmd.load_out = !r_second && i_stat.out_free;
            end
            ST_REREAD: begin
                o_cmd.read_again = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_update_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_UPDATE |-> $past(r_state) == ST_LOOKUP)
        else $error("write-back without a preceding compare");

    a_reread_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_REREAD |-> !r_second && $past(r_second))
        else $error("second access without a pending modify");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state != ST_IDLE)
        else $error("item accepted but sequencer stayed idle");

endmodule

// ===== hw/rtl/slc_datapath.sv =====
// ----------------------------------------------------------------------------
// slc_datapath: set memories, way compare, LRU ages and totals
// Holds the configuration registers, the tag and state memories (one row per
// set), the registered compare decision, the saturating totals and the
// output register.
// ----------------------------------------------------------------------------
module slc_datapath #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  slc_pkg::t_ctrl_cmd                 i_cmd,
    output slc_pkg::t_ctrl_stat                o_stat,
    input  logic [slc_pkg::ADDR_W-1:0]         i_address,
    input  logic                               i_cfg_valid,
    input  logic [slc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_first_hit,
    output logic                               o_evicted,
    output logic [slc_pkg::CNT_W-1:0]          o_total_hits,
    output logic [slc_pkg::CNT_W-1:0]          o_total_misses,
    output logic [slc_pkg::CNT_W-1:0]          o_total_evictions
);
    import slc_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1) + 1;
    localparam logic [WAY_W-1:0] RANK_MAX = WAY_W'(MAX_WAYS - 1);

    // configuration
    logic [2:0] r_set_bits;
    logic [5:0] r_block_bits;
    logic [3:0] r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= 4'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                default:        r_set_bits   <= r_set_bits;
            endcase
        end
    end

    // address split and ways in use
    logic [2:0]          sb;
    logic [6:0]          sh;
    logic [IDX_W-1:0]    idx_mask;
    logic [ADDR_W-1:0]   idx_shift;
    logic [IDX_W-1:0]    idx_in;
    logic [ADDR_W-1:0]   tag_in;
    logic [NW_W-1:0]     nw;
    logic [MAX_WAYS-1:0] way_used;

    always_comb begin
        sb        = (int'(r_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : r_set_bits;
        sh        = {4'b0, sb} + {1'b0, r_block_bits};
        tag_in    = i_address >> sh;
        idx_shift = i_address >> r_block_bits;
        idx_mask  = ~({IDX_W{1'b1}} << sb);
        idx_in    = idx_shift[IDX_W-1:0] & idx_mask;
        if (r_ways == 4'd0) begin
            nw = NW_W'(1);
        end else if (NW_W'(r_ways) > NW_W'(MAX_WAYS)) begin
            nw = NW_W'(MAX_WAYS);
        end else begin
            nw = NW_W'(r_ways);
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_used[w] = NW_W'(w) < nw;
        end
    end

    // item registers
    logic [ADDR_W-1:0] r_tag;
    logic [IDX_W-1:0]  r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag <= tag_in;
            r_idx <= idx_in;
        end
    end

    // set memories
    logic [MAX_WAYS-1:0]                 mem_valid [SETS];
    logic [MAX_WAYS-1:0][WAY_W-1:0]      mem_rank  [SETS];
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     mem_tag   [SETS];

    logic [MAX_WAYS-1:0]                 r_rd_valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0]      r_rd_rank;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     r_rd_tag;

    logic [MAX_WAYS-1:0]                 wr_valid;
    logic [MAX_WAYS-1:0][WAY_W-1:0]      wr_rank;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     wr_tag;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] r_clr_idx;

    assign rd_en   = i_cmd.read_in || i_cmd.read_again;
    assign rd_addr = i_cmd.read_in ? idx_in : r_idx;
    assign wr_addr = i_cmd.clear ? r_clr_idx : r_idx;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_valid <= mem_valid[rd_addr];
            r_rd_rank  <= mem_rank[rd_addr];
            r_rd_tag   <= mem_tag[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_valid[wr_addr] <= '0;
            mem_rank[wr_addr]  <= '0;
        end else if (i_cmd.update) begin
            mem_valid[wr_addr] <= wr_valid;
            mem_rank[wr_addr]  <= wr_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            mem_tag[wr_addr] <= wr_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
        end
    end

    assign o_stat.clr_last = (r_clr_idx == IDX_W'(SETS - 1));

    // way compare
    logic             hit_c;
    logic [WAY_W-1:0] hit_way_c;
    logic             empty_c;
    logic [WAY_W-1:0] empty_way_c;
    logic [WAY_W-1:0] victim_c;
    logic [WAY_W-1:0] oldest_c;

    always_comb begin
        hit_c       = 1'b0;
        hit_way_c   = '0;
        empty_c     = 1'b0;
        empty_way_c = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (way_used[w] && r_rd_valid[w] && (r_rd_tag[w] == r_tag)) begin
                hit_c     = 1'b1;
                hit_way_c = WAY_W'(w);
            end
            if (way_used[w] && !r_rd_valid[w]) begin
                empty_c     = 1'b1;
                empty_way_c = WAY_W'(w);
            end
        end
        victim_c = '0;
        oldest_c = r_rd_rank[0];
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (way_used[w] && (r_rd_rank[w] > oldest_c)) begin
                oldest_c = r_rd_rank[w];
                victim_c = WAY_W'(w);
            end
        end
    end

    logic             r_hit;
    logic             r_evict;
    logic [WAY_W-1:0] r_way;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit   <= hit_c;
            r_evict <= !hit_c && !empty_c;
            if (hit_c) begin
                r_way <= hit_way_c;
            end else if (empty_c) begin
                r_way <= empty_way_c;
            end else begin
                r_way <= victim_c;
            end
        end
    end

    // row write-back with age update
    logic [WAY_W-1:0] hit_rank;

    always_comb begin
        hit_rank = r_rd_rank[r_way];
        wr_valid = r_rd_valid;
        wr_rank  = r_rd_rank;
        wr_tag   = r_rd_tag;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (way_used[w] && r_rd_valid[w] && (WAY_W'(w) != r_way)
                    && (!r_hit || (r_rd_rank[w] < hit_rank))
                    && (r_rd_rank[w] != RANK_MAX)) begin
                wr_rank[w] = r_rd_rank[w] + WAY_W'(1);
            end
        end
        wr_valid[r_way] = 1'b1;
        wr_rank[r_way]  = '0;
        wr_tag[r_way]   = r_tag;
    end

    // totals and item flags
    logic [CNT_W-1:0] r_hits, n_hits;
    logic [CNT_W-1:0] r_misses, n_misses;
    logic [CNT_W-1:0] r_evicts, n_evicts;
    logic             r_first_hit, n_first_hit;
    logic             r_item_evict, n_item_evict;

    always_comb begin
        n_hits       = r_hits;
        n_misses     = r_misses;
        n_evicts     = r_evicts;
        n_first_hit  = r_first_hit;
        n_item_evict = r_item_evict;
        if (i_cmd.accept) begin
            n_first_hit  = 1'b0;
            n_item_evict = 1'b0;
        end else if (i_cmd.update) begin
            if (r_hit) begin
                if (r_hits != '1) begin
                    n_hits = r_hits + CNT_W'(1);
                end
            end else if (r_misses != '1) begin
                n_misses = r_misses + CNT_W'(1);
            end
            if (r_evict) begin
                n_item_evict = 1'b1;
                if (r_evicts != '1) begin
                    n_evicts = r_evicts + CNT_W'(1);
                end
            end
            if (i_cmd.first) begin
                n_first_hit = r_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_evicts <= n_evicts;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_hit  <= n_first_hit;
        r_item_evict <= n_item_evict;
    end

    // output register
    logic r_out_valid;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_first_hit       <= n_first_hit;
            o_evicted         <= n_item_evict;
            o_total_hits      <= n_hits;
            o_total_misses    <= n_misses;
            o_total_evictions <= n_evicts;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_hits_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_hits >= $past(r_hits))
        else $error("hit total decreased");

    a_evicts_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_evicts >= $past(r_evicts))
        else $error("eviction total decreased");

endmodule

// ===== hw/rtl/set_assoc_lru_cache_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim: tag-only set-associative cache with true LRU
//
//   channel  handshake                 payload
//   in       i_in_valid / o_in_ready   i_kind, i_address
//   out      o_out_valid / i_out_ready o_first_hit, o_evicted, o_total_*
//   cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A load or store steps through set read, way compare and row write-back;
// a modify repeats the access through the single set read port; an unused
// kind skips all three and goes straight to the output register.
// After reset a clearing pass empties all 2**MAX_SET_BITS sets;
// no item is accepted until it ends, configuration writes are taken always.
// A result waits in the output register; a stalled output holds the next
// item after its write-back until the register frees.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [slc_pkg::KIND_W-1:0]         i_kind,
    input  logic [slc_pkg::ADDR_W-1:0]         i_address,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_first_hit,
    output logic                               o_evicted,
    output logic [slc_pkg::CNT_W-1:0]          o_total_hits,
    output logic [slc_pkg::CNT_W-1:0]          o_total_misses,
    output logic [slc_pkg::CNT_W-1:0]          o_total_evictions,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [slc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import slc_pkg::*;

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    assign o_cfg_ready = 1'b1;

    slc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    slc_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_address         (i_address),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_first_hit       (o_first_hit),
        .o_evicted         (o_evicted),
        .o_total_hits      (o_total_hits),
        .o_total_misses    (o_total_misses),
        .o_total_evictions (o_total_evictions)
    );

endmodule

// ===== tb/set_assoc_lru_cache_sim_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_tb: self-checking bench of the LRU cache model
// A stimulus table covers reset behavior, address and register extremes,
// duplicate tags, the unused access kind and LRU eviction order. Random
// phases then replay conflicting address pools under random settings and
// idle patterns. Each result is checked against a table value or a predictor.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_tb;
    import slc_pkg::*;

    localparam int SET_CAP     = 6;
    localparam int WAY_CAP     = 8;
    localparam int LINE_TOTAL  = (1 << SET_CAP) * WAY_CAP;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 66;
    localparam int TAIL_CYCLES = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             first_hit;
        logic             evicted;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } t_cache_result;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [KIND_W-1:0]      kind;
        logic [ADDR_W-1:0]      address;
        logic                   typed;
        t_cache_result          want;
    } t_plan_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic [KIND_W-1:0]      i_kind      = KIND_LOAD;
    logic [ADDR_W-1:0]      i_address   = '0;
    logic                   i_out_ready = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic                   o_first_hit;
    logic                   o_evicted;
    logic [CNT_W-1:0]       o_total_hits;
    logic [CNT_W-1:0]       o_total_misses;
    logic [CNT_W-1:0]       o_total_evictions;
    logic                   o_cfg_ready;

    int in_idle_pct  = 11;
    int out_idle_pct = 64;
    int items_sent, modify_items, unused_items, results_checked;
    int hits_seen, evicts_seen, reg_writes, mismatches;

    t_cache_result expected_results [$];
    t_plan_row     directed_plan [$];

    logic                 line_ok  [LINE_TOTAL];
    logic [ADDR_W-1:0]    line_tag [LINE_TOTAL];
    logic [2:0]           line_age [LINE_TOTAL];
    logic [CNT_W-1:0]     model_hits, model_misses, model_evicts;
    logic [2:0]           model_set;
    logic [5:0]           model_block;
    logic [3:0]           model_ways;

    set_assoc_lru_cache_sim #(
        .MAX_SET_BITS(SET_CAP),
        .MAX_WAYS    (WAY_CAP)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_first_hit      (o_first_hit),
        .o_evicted        (o_evicted),
        .o_total_hits     (o_total_hits),
        .o_total_misses   (o_total_misses),
        .o_total_evictions(o_total_evictions),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void reset_model();
        for (int i = 0; i < LINE_TOTAL; i++) begin
            line_ok[i]  = 1'b0;
            line_age[i] = '0;
        end
        model_hits   = '0;
        model_misses = '0;
        model_evicts = '0;
        model_set    = '0;
        model_block  = '0;
        model_ways   = 4'd1;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] offset_mask();
        return (64'd1 << model_block) - 64'd1;
    endfunction

    // returns {hit, evicted} for one access
    function automatic logic [1:0] touch_line(input logic [ADDR_W-1:0] addr);
        int sb, sh, nw, base, found, victim;
        logic [ADDR_W-1:0] tag, idx;
        logic evicted;
        sb   = (model_set > SET_CAP) ? SET_CAP : model_set;
        sh   = sb + model_block;
        tag  = (sh >= ADDR_W) ? '0 : addr >> sh;
        idx  = (model_block >= ADDR_W) ? '0 : (addr >> model_block) & ((64'd1 << sb) - 64'd1);
        nw   = (model_ways == 0) ? 1 : (model_ways > WAY_CAP) ? WAY_CAP : model_ways;
        base = int'(idx) * WAY_CAP;
        found = -1;
        for (int w = 0; w < nw; w++) begin
            if (found < 0 && line_ok[base+w] && line_tag[base+w] == tag) found = w;
        end
        if (found >= 0) begin
            for (int w = 0; w < nw; w++) begin
                if (w != found && line_ok[base+w] && line_age[base+w] < line_age[base+found]
                    && line_age[base+w] < WAY_CAP - 1)
                    line_age[base+w]++;
            end
            line_age[base+found] = '0;
            model_hits = bump(model_hits);
            return 2'b10;
        end
        model_misses = bump(model_misses);
        victim  = -1;
        evicted = 1'b0;
        for (int w = 0; w < nw; w++) begin
            if (victim < 0 && !line_ok[base+w]) victim = w;
        end
        if (victim < 0) begin
            victim = 0;
            for (int w = 1; w < nw; w++) begin
                if (line_age[base+w] > line_age[base+victim]) victim = w;
            end
            model_evicts = bump(model_evicts);
            evicted = 1'b1;
        end
        for (int w = 0; w < nw; w++) begin
            if (w != victim && line_ok[base+w] && line_age[base+w] < WAY_CAP - 1)
                line_age[base+w]++;
        end
        line_ok[base+victim]  = 1'b1;
        line_tag[base+victim] = tag;
        line_age[base+victim] = '0;
        return {1'b0, evicted};
    endfunction

    function automatic t_cache_result predict_access(input logic [KIND_W-1:0] kind,
                                                     input logic [ADDR_W-1:0] addr);
        t_cache_result r;
        logic [1:0] acc;
        r = '0;
        if (kind != KIND_NONE) begin
            acc = touch_line(addr);
            r.first_hit = acc[1];
            r.evicted   = acc[0];
            if (kind == KIND_MODIFY) begin
                acc = touch_line(addr);
                r.evicted = r.evicted | acc[0];
            end
        end
        r.hits      = model_hits;
        r.misses    = model_misses;
        r.evictions = model_evicts;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] compose_address(input logic [ADDR_W-1:0] tag,
                                                          input logic [ADDR_W-1:0] set_sel,
                                                          input logic [ADDR_W-1:0] off);
        int sb, sh;
        logic [ADDR_W-1:0] a;
        sb = (model_set > SET_CAP) ? SET_CAP : model_set;
        sh = sb + model_block;
        a  = off & offset_mask();
        if (sh < ADDR_W) a = a | (tag << sh);
        a = a | ((set_sel & ((64'd1 << sb) - 64'd1)) << model_block);
        return a;
    endfunction

    function automatic t_cache_result outcome(input int fh, input int ev, input int h,
                                              input int m, input int e);
        return {fh[0], ev[0], h[CNT_W-1:0], m[CNT_W-1:0], e[CNT_W-1:0]};
    endfunction

    function automatic void plan_access(input logic [KIND_W-1:0] kind,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic typed, input t_cache_result want);
        directed_plan.push_back({1'b0, CFG_SET_BITS, 6'd0, kind, addr, typed, want});
    endfunction

    function automatic void plan_cfg(input logic [CFG_INDEX_W-1:0] index,
                                     input logic [CFG_DATA_W-1:0] data);
        directed_plan.push_back({1'b1, index, data, KIND_LOAD, 64'd0, 1'b0,
                                 t_cache_result'(0)});
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                             input logic typed, input t_cache_result want);
        t_cache_result predicted;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_address  <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_access(kind, addr);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
        if (kind == KIND_MODIFY) modify_items++;
        if (kind == KIND_NONE) unused_items++;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_SET_BITS:   model_set   = data[2:0];
            CFG_BLOCK_BITS: model_block = data;
            CFG_WAYS:       model_ways  = data[3:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic check_result();
        t_cache_result got, exp;
        got = {o_first_hit, o_evicted, o_total_hits, o_total_misses, o_total_evictions};
        results_checked++;
        if (got.first_hit) hits_seen++;
        if (got.evicted) evicts_seen++;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: hit=%0d ev=%0d hits=%0d misses=%0d evictions=%0d",
                         got.first_hit, got.evicted, got.hits, got.misses, got.evictions);
        end else begin
            exp = expected_results.pop_front();
            if (got.first_hit !== exp.first_hit || got.evicted !== exp.evicted ||
                got.hits !== exp.hits || got.misses !== exp.misses ||
                got.evictions !== exp.evictions) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected hit=%0d ev=%0d %0d/%0d/%0d, got hit=%0d ev=%0d %0d/%0d/%0d",
                             results_checked, exp.first_hit, exp.evicted, exp.hits,
                             exp.misses, exp.evictions, got.first_hit, got.evicted,
                             got.hits, got.misses, got.evictions);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result();
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int pool_size;
        int unsigned pick;
        logic [ADDR_W-1:0] addr_pool [16];
        logic [ADDR_W-1:0] set_a, set_b, rnd, addr;
        logic [31:0] hi;
        logic [KIND_W-1:0] kind;
        logic [2:0] sb_sel;
        logic [5:0] bb_sel;
        logic [3:0] way_sel;

        reset_model();

        // reset settings: one set, one way, no offset
        plan_access(KIND_LOAD,   64'd0,  1'b1, outcome(0, 0, 0, 1, 0));
        plan_access(KIND_LOAD,   64'd0,  1'b1, outcome(1, 0, 1, 1, 0));
        plan_access(KIND_STORE,  '1,     1'b1, outcome(0, 1, 1, 2, 1));
        plan_access(KIND_MODIFY, '1,     1'b1, outcome(1, 0, 3, 2, 1));
        plan_access(KIND_MODIFY, 64'd0,  1'b1, outcome(0, 1, 4, 3, 2));
        plan_access(KIND_NONE,   64'h5A5A_A5A5_0F0F_F0F0, 1'b1, outcome(0, 0, 4, 3, 2));
        plan_cfg(CFG_UNUSED, 6'h2A);
        // build two ways with the same tag
        plan_cfg(CFG_WAYS, 6'd2);
        plan_access(KIND_LOAD, 64'h30, 1'b0, '0);
        plan_cfg(CFG_WAYS, 6'd1);
        plan_access(KIND_LOAD, 64'h30, 1'b0, '0);
        plan_cfg(CFG_WAYS, 6'd2);
        plan_access(KIND_LOAD, 64'h30, 1'b0, '0);
        // out-of-range register values
        plan_cfg(CFG_SET_BITS,   6'h3F);
        plan_cfg(CFG_BLOCK_BITS, 6'h3F);
        plan_cfg(CFG_WAYS,       6'h3F);
        plan_access(KIND_LOAD,   '1, 1'b0, '0);
        plan_access(KIND_LOAD,   64'h8000_0000_0000_0000, 1'b0, '0);
        plan_access(KIND_LOAD,   64'd0, 1'b0, '0);
        plan_access(KIND_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0);
        plan_cfg(CFG_SET_BITS,   6'd0);
        plan_cfg(CFG_BLOCK_BITS, 6'd0);
        plan_cfg(CFG_WAYS,       6'd0);
        plan_access(KIND_LOAD,  64'h30, 1'b0, '0);
        plan_access(KIND_STORE, 64'h31, 1'b0, '0);
        // four ways in set zero, then evict the oldest
        plan_cfg(CFG_SET_BITS,   6'd2);
        plan_cfg(CFG_BLOCK_BITS, 6'd4);
        plan_cfg(CFG_WAYS,       6'd4);
        plan_access(KIND_LOAD,   64'h000, 1'b0, '0);
        plan_access(KIND_LOAD,   64'h040, 1'b0, '0);
        plan_access(KIND_STORE,  64'h080, 1'b0, '0);
        plan_access(KIND_LOAD,   64'h0C0, 1'b0, '0);
        plan_access(KIND_LOAD,   64'h00F, 1'b0, '0);
        plan_access(KIND_STORE,  64'h100, 1'b0, '0);
        plan_access(KIND_MODIFY, 64'h040, 1'b0, '0);
        plan_access(KIND_NONE,   '1,      1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg)
                write_register(directed_plan[i].reg_index, directed_plan[i].reg_data);
            else
                send_item(directed_plan[i].kind, directed_plan[i].address,
                          directed_plan[i].typed, directed_plan[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 2) begin
                in_idle_pct  = 64;
                out_idle_pct = 11;
            end else if (phase == 4) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            hi      = $urandom;
            sb_sel  = 3'($urandom_range(0, 7));
            bb_sel  = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(56, 63))
                                                  : 6'($urandom_range(0, 8));
            way_sel = 4'($urandom_range(0, 15));
            write_register(CFG_SET_BITS,   {hi[2:0], sb_sel});
            write_register(CFG_BLOCK_BITS, bb_sel);
            write_register(CFG_WAYS,       {hi[5:4], way_sel});

            // conflicting lines spread over two sets
            set_a     = {$urandom, $urandom};
            set_b     = {$urandom, $urandom};
            pool_size = $urandom_range(3, 16);
            for (int k = 0; k < pool_size; k++)
                addr_pool[k] = compose_address({$urandom, $urandom}, k[0] ? set_a : set_b,
                                               {$urandom, $urandom});

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rnd  = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 80)
                    addr = addr_pool[$urandom_range(0, pool_size - 1)] ^ (rnd & offset_mask());
                else
                    addr = rnd;
                pick = $urandom_range(0, 15);
                kind = (pick < 5) ? KIND_LOAD : (pick < 10) ? KIND_STORE :
                       (pick < 15) ? KIND_MODIFY : KIND_NONE;
                if ($urandom_range(0, 49) == 0) wait_drained();
                send_item(kind, addr, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d items (%0d modify, %0d unused kind) over %0d register writes",
                 items_sent, modify_items, unused_items, reg_writes);
        $display("checked %0d results: %0d first-access hits, %0d with eviction, %0d mismatches",
                 results_checked, hits_seen, evicts_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
